FILE: rtl/core/tcct_pkg.sv
// tcct_pkg: shared types, constants and segment helpers for the thermal code
// calibrate-and-trip block
// no dependencies; used by the interfaces and every module under rtl/core
package tcct_pkg;

  // field widths
  localparam int CODE_BITS    = 12;
  localparam int EMU_BITS     = 22;
  localparam int CAL_OUT_BITS = 15;
  localparam int GAIN_BITS    = 10;
  localparam int OFS_BITS     = 6;

  // apb port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // datapath widths
  localparam int FAC_W  = 15;               // 8192 + trim, and 3*m25 - m75
  localparam int MD_W   = CODE_BITS + 1;    // m75 - m25
  localparam int QP_W   = 2 * FAC_W;        // offset product
  localparam int NUM_W  = QP_W;             // corrected numerator
  localparam int DIFF_W = CODE_BITS + 1;    // standard code difference
  localparam int DEN_W  = FAC_W + MD_W;     // divisor
  localparam int DVD_W  = NUM_W + DIFF_W;   // dividend
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int CAL_W  = 32;               // |quotient| < 2^30 since |divisor| >= 7925
  localparam int TMP_W  = CAL_W + 10;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_F_W    = $clog2(FIFO_DEPTH + 1);

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic signed [EMU_BITS-1:0] temp_t;
  typedef logic signed [GAIN_BITS-1:0] gain_t;
  typedef logic signed [OFS_BITS-1:0] ofs_t;

  localparam code_t CODE_FAIL = '1;

  // constants of the correction
  localparam logic signed [FAC_W-1:0] FRAC_ONE     = 15'sd8192;
  localparam logic signed [CAL_W-1:0] PKG_COMP_ADD = 32'sd18;
  localparam logic signed [TMP_W-1:0] TEMP_SCALE   = 42'sd440;      // 10 * 44
  localparam logic signed [TMP_W-1:0] TEMP_BIAS    = 42'sd1190156;  // 27049 * 44
  localparam logic signed [CAL_W-1:0] CAL_MIN      = -32'sd8192;
  localparam logic signed [CAL_W-1:0] CAL_MAX      = 32'sd16383;
  localparam logic signed [TMP_W-1:0] TEMP_MIN     = -42'sd2097152;
  localparam logic signed [TMP_W-1:0] TEMP_MAX     = 42'sd2097151;
  localparam temp_t HOT_LIMIT  = 22'sd90000;
  localparam temp_t CRIT_LIMIT = 22'sd110000;

  // register map
  typedef enum logic [2:0] {
    REG_SEG_UPPER  = 3'd0,
    REG_SEG_MID    = 3'd1,
    REG_SEG_LOW    = 3'd2,
    REG_SEG_BOTTOM = 3'd3,
    REG_M25        = 3'd4,
    REG_M75        = 3'd5,
    REG_PKG_COMP   = 3'd6,
    REG_EMU_TEMP   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    code_t seg_upper;
    code_t seg_mid;
    code_t seg_low;
    code_t seg_bottom;
    code_t m25;
    code_t m75;
    logic  pkg_comp;
    temp_t emu_temp;
  } cfg_t;

  // calibration segments, top to bottom
  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_TOP,
    SEG_HIGH,
    SEG_MID_HI,
    SEG_MID_LO,
    SEG_LOW,
    SEG_BELOW,
    SEG_BOTTOM
  } seg_t;

  typedef struct packed {
    code_t code;
    seg_t  seg;
  } item_t;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_ENTER = 2'd1,
    EVT_LEAVE = 2'd2
  } hot_evt_t;

  // first match wins; even with misordered thresholds every code lands in a segment
  function automatic seg_t classify(input code_t c, input cfg_t cfg);
    seg_t s;
    s = SEG_NONE;
    if (c > cfg.seg_upper)                          s = SEG_TOP;
    else if (cfg.m75 < c && c <= cfg.seg_upper)     s = SEG_HIGH;
    else if (c > cfg.seg_mid && c <= cfg.m75)       s = SEG_MID_HI;
    else if (cfg.m25 < c && c <= cfg.seg_mid)       s = SEG_MID_LO;
    else if (c >= cfg.seg_low && cfg.m25 >= c)      s = SEG_LOW;
    else if (cfg.seg_bottom <= c && cfg.seg_low > c) s = SEG_BELOW;
    else if (cfg.seg_bottom > c)                    s = SEG_BOTTOM;
    return s;
  endfunction

  // gain trim per segment
  function automatic gain_t seg_gain(input seg_t s);
    gain_t k;
    case (s)
      SEG_TOP:    k = 10'sd198;
      SEG_HIGH:   k = 10'sd41;
      SEG_MID_HI: k = -10'sd111;
      SEG_MID_LO: k = 10'sd111;
      SEG_LOW:    k = -10'sd233;
      SEG_BELOW:  k = -10'sd250;
      SEG_BOTTOM: k = -10'sd267;
      default:    k = '0;
    endcase
    return k;
  endfunction

  // offset trim per segment
  function automatic ofs_t seg_offset(input seg_t s);
    ofs_t t;
    case (s)
      SEG_TOP:    t = -6'sd16;
      SEG_HIGH:   t = -6'sd3;
      SEG_MID_HI: t = 6'sd7;
      SEG_MID_LO: t = -6'sd2;
      SEG_LOW, SEG_BELOW, SEG_BOTTOM: t = 6'sd5;
      default:    t = '0;
    endcase
    return t;
  endfunction

  // sequencer of the back part
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_QPROD,
    BK_NUMDEN,
    BK_DVD,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_CAL,
    BK_SCALE,
    BK_SAT,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/core/tcct_in_if.sv
// tcct_in_if: request channel carrying one raw sensor code
// depends on tcct_pkg for the code width
interface tcct_in_if;
  logic                 valid;
  logic                 ready;
  tcct_pkg::code_t      sensor_code;

  modport source (output valid, output sensor_code, input ready);
  modport sink   (input valid, input sensor_code, output ready);
endinterface

FILE: rtl/core/tcct_out_if.sv
// tcct_out_if: result channel carrying the calibrated code, temperature and flags
// depends on tcct_pkg for field widths
interface tcct_out_if;
  logic                                       valid;
  logic                                       ready;
  tcct_pkg::code_t                            code_used;
  logic signed [tcct_pkg::CAL_OUT_BITS-1:0]   calibrated_code;
  tcct_pkg::temp_t                            temp_millideg;
  logic                                       hot_now;
  logic [1:0]                                 hot_event;
  logic                                       critical;

  modport source (output valid, output code_used, output calibrated_code,
                  output temp_millideg, output hot_now, output hot_event,
                  output critical, input ready);
  modport sink   (input valid, input code_used, input calibrated_code,
                  input temp_millideg, input hot_now, input hot_event,
                  input critical, output ready);
endinterface

FILE: rtl/core/thermal_code_calibrate_and_trip.sv
// thermal_code_calibrate_and_trip: top level joining registers, front, queue
// and back; depends on tcct_pkg, tcct_in_if, tcct_out_if and all tcct modules
//
//   channel   direction  handshake          payload
//   sample    in         valid / ready      sensor_code
//   result    out        valid / ready      code_used, calibrated_code,
//                                           temp_millideg, hot_now,
//                                           hot_event, critical
//   apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// the back part runs each request through its sequencer steps and the 43-bit
// restoring divider, one quotient bit per cycle, then waits in its done state
// until the output register is free.
// the front takes requests while the queue has room, up to two ahead of the back.
// rst is synchronous and clears the queue, sequencer, held code and hot flag.
// a stalled result holds in the output register while the next request is
// already being worked; the back waits only when it has a new result to place.
module thermal_code_calibrate_and_trip #(
  parameter int STD_CODE_25C = 2762,
  parameter int STD_CODE_75C = 2875
) (
  input  logic                          clk,
  input  logic                          rst,
  tcct_in_if.sink                       sample,
  tcct_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcct_pkg::APB_AW-1:0]   paddr,
  input  logic [tcct_pkg::APB_DW-1:0]   pwdata,
  output logic [tcct_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tcct_pkg::*;

  cfg_t  cfg;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_in;
  item_t q_head;

  // configuration registers
  tcct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept and classify
  tcct_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  // decoupling queue
  tcct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // correction, scaling and trip flags
  tcct_back #(
    .STD_CODE_25C (STD_CODE_25C),
    .STD_CODE_75C (STD_CODE_75C)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

FILE: rtl/core/tcct_regs.sv
// tcct_regs: apb configuration registers with reset values and read-back
// depends on tcct_pkg
module tcct_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcct_pkg::APB_AW-1:0]   paddr,
  input  logic [tcct_pkg::APB_DW-1:0]   pwdata,
  output logic [tcct_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output tcct_pkg::cfg_t                cfg
);
  import tcct_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes, masked to each field
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg_upper  <= 12'd3100;
      cfg.seg_mid    <= 12'd2818;
      cfg.seg_low    <= 12'd2600;
      cfg.seg_bottom <= 12'd2400;
      cfg.m25        <= 12'd2762;
      cfg.m75        <= 12'd2875;
      cfg.pkg_comp   <= 1'b0;
      cfg.emu_temp   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEG_UPPER:  cfg.seg_upper  <= pwdata[CODE_BITS-1:0];
        REG_SEG_MID:    cfg.seg_mid    <= pwdata[CODE_BITS-1:0];
        REG_SEG_LOW:    cfg.seg_low    <= pwdata[CODE_BITS-1:0];
        REG_SEG_BOTTOM: cfg.seg_bottom <= pwdata[CODE_BITS-1:0];
        REG_M25:        cfg.m25        <= pwdata[CODE_BITS-1:0];
        REG_M75:        cfg.m75        <= pwdata[CODE_BITS-1:0];
        REG_PKG_COMP:   cfg.pkg_comp   <= pwdata[0];
        REG_EMU_TEMP:   cfg.emu_temp   <= signed'(pwdata[EMU_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (idx)
      REG_SEG_UPPER:  prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.seg_upper};
      REG_SEG_MID:    prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.seg_mid};
      REG_SEG_LOW:    prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.seg_low};
      REG_SEG_BOTTOM: prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.seg_bottom};
      REG_M25:        prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.m25};
      REG_M75:        prdata = {{(APB_DW-CODE_BITS){1'b0}}, cfg.m75};
      REG_PKG_COMP:   prdata = {{(APB_DW-1){1'b0}}, cfg.pkg_comp};
      REG_EMU_TEMP:   prdata = {{(APB_DW-EMU_BITS){cfg.emu_temp[EMU_BITS-1]}}, cfg.emu_temp};
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/tcct_front.sv
// tcct_front: accepts sensor codes, substitutes the last good code on a failed
// read and sorts the code into its calibration segment; depends on tcct_pkg
module tcct_front (
  input  logic              clk,
  input  logic              rst,
  tcct_in_if.sink           sample,
  input  tcct_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output tcct_pkg::item_t   q_item
);
  import tcct_pkg::*;

  code_t last_good_code;
  code_t code_sel;
  logic  failed;

  assign sample.ready = !q_full;
  assign q_push       = sample.valid && !q_full;

  // failed read reuses the held code
  assign failed   = (sample.sensor_code == CODE_FAIL);
  assign code_sel = failed ? last_good_code : sample.sensor_code;

  assign q_item.code = code_sel;
  assign q_item.seg  = classify(code_sel, cfg);

  // hold last good code
  always_ff @(posedge clk) begin
    if (rst) begin
      last_good_code <= '0;
    end else if (q_push && !failed) begin
      last_good_code <= sample.sensor_code;
    end
  end

endmodule

FILE: rtl/core/tcct_fifo.sv
// tcct_fifo: short queue of classified requests between front and back
// depends on tcct_pkg for the entry type and depth
module tcct_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcct_pkg::item_t   push_item,
  output logic              full,
  input  logic              pop,
  output tcct_pkg::item_t   head,
  output logic              empty
);
  import tcct_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_F_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_F_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/core/tcct_div.sv
// tcct_div: signed restoring divider, one quotient bit per cycle, truncates
// toward zero; depends on tcct_pkg for operand widths
module tcct_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [tcct_pkg::DVD_W-1:0]     dividend,
  input  logic signed [tcct_pkg::DEN_W-1:0]     divisor,
  output logic                                  done,
  output logic signed [tcct_pkg::DVD_W-1:0]     quotient
);
  import tcct_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   acc;       // dividend bits in, quotient bits out
  logic [DEN_W-1:0]   dsr;
  logic [DEN_W-1:0]   rem;
  logic               neg;
  logic [DEN_W:0]     trial;
  logic               fits;

  // one restoring step
  assign trial = {rem, acc[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dsr <= divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
      rem <= '0;
      neg <= dividend[DVD_W-1] ^ divisor[DEN_W-1];
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, dsr}) : trial[DEN_W-1:0];
      acc <= {acc[DVD_W-2:0], fits};
    end
  end

  assign quotient = neg ? signed'(DVD_W'(~acc + 1'b1)) : signed'(acc);

endmodule

FILE: rtl/core/tcct_back.sv
// tcct_back: sequencer that runs the two-point correction, temperature scaling
// and trip flags for one request at a time; depends on tcct_pkg and tcct_div
module tcct_back #(
  parameter int STD_CODE_25C = 2762,
  parameter int STD_CODE_75C = 2875
) (
  input  logic              clk,
  input  logic              rst,
  input  tcct_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  tcct_pkg::item_t   q_head,
  output logic              q_pop,
  tcct_out_if.source        result
);
  import tcct_pkg::*;

  localparam int STD_DIFF = STD_CODE_75C - STD_CODE_25C;
  localparam int CAL_OFS  = (3 * STD_CODE_25C - STD_CODE_75C) / 2;
  localparam logic signed [DIFF_W-1:0] DIFF_S    = DIFF_W'(STD_DIFF);
  localparam logic signed [CAL_W-1:0]  CAL_OFS_S = CAL_W'(CAL_OFS);

  back_state_t state, state_next;

  code_t                    code;
  gain_t                    gain;
  ofs_t                     ofs;
  logic signed [QP_W-1:0]   qprod;
  logic signed [NUM_W-1:0]  num;
  logic signed [DEN_W-1:0]  den;
  logic signed [DVD_W-1:0]  dvd;
  logic                     den_zero;
  logic signed [CAL_W-1:0]  cal;
  logic signed [TMP_W-1:0]  tmp;
  temp_t                    temp;
  logic signed [CAL_OUT_BITS-1:0] cal_sat;
  logic                     hot_flag;

  logic signed [FAC_W-1:0]  fac_ofs;
  logic signed [FAC_W-1:0]  fac_gain;
  logic signed [FAC_W-1:0]  m25_s;
  logic signed [FAC_W-1:0]  m75_s;
  logic signed [FAC_W-1:0]  m_comb;
  logic signed [MD_W-1:0]   m_diff;
  logic signed [QP_W-1:0]   qsum;
  logic signed [QP_W-1:0]   qhalf;
  logic signed [CAL_W-1:0]  quot_c;
  logic signed [TMP_W-1:0]  tmp_sat;

  logic                     div_start;
  logic                     div_done;
  logic signed [DVD_W-1:0]  div_quot;

  logic                     out_free;
  logic                     load_out;
  logic                     hot;
  hot_evt_t                 evt;

  tcct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quot)
  );

  // trim factors and measured code terms
  assign fac_ofs  = FRAC_ONE + signed'({{(FAC_W-OFS_BITS){ofs[OFS_BITS-1]}}, ofs});
  assign fac_gain = FRAC_ONE + signed'({{(FAC_W-GAIN_BITS){gain[GAIN_BITS-1]}}, gain});
  assign m25_s    = signed'({{(FAC_W-CODE_BITS){1'b0}}, cfg.m25});
  assign m75_s    = signed'({{(FAC_W-CODE_BITS){1'b0}}, cfg.m75});
  assign m_comb   = m25_s + m25_s + m25_s - m75_s;
  assign m_diff   = signed'({1'b0, cfg.m75}) - signed'({1'b0, cfg.m25});

  // halve toward zero
  assign qsum  = qprod + QP_W'(qprod[QP_W-1]);
  assign qhalf = qsum >>> 1;

  // quotient fits well inside the calibration width
  assign quot_c = den_zero ? '0 : div_quot[CAL_W-1:0];

  // temperature saturation
  always_comb begin
    if (tmp < TEMP_MIN)      tmp_sat = TEMP_MIN;
    else if (tmp > TEMP_MAX) tmp_sat = TEMP_MAX;
    else                     tmp_sat = tmp;
  end

  // hot tracking on the final temperature
  assign out_free = !result.valid || result.ready;
  assign hot      = (temp > HOT_LIMIT);
  always_comb begin
    if (hot && !hot_flag)      evt = EVT_ENTER;
    else if (!hot && hot_flag) evt = EVT_LEAVE;
    else                       evt = EVT_NONE;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_QPROD;
        end
      end
      BK_QPROD:    state_next = BK_NUMDEN;
      BK_NUMDEN:   state_next = BK_DVD;
      BK_DVD:      state_next = BK_DIV_GO;
      BK_DIV_GO: begin
        div_start  = 1'b1;
        state_next = BK_DIV_WAIT;
      end
      BK_DIV_WAIT: if (div_done) state_next = BK_CAL;
      BK_CAL:      state_next = BK_SCALE;
      BK_SCALE:    state_next = BK_SAT;
      BK_SAT:      state_next = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default:     state_next = BK_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        code <= q_head.code;
        gain <= seg_gain(q_head.seg);
        ofs  <= seg_offset(q_head.seg);
      end
      BK_QPROD:  qprod <= fac_ofs * m_comb;
      BK_NUMDEN: begin
        num <= signed'({{(NUM_W-CODE_BITS-13){1'b0}}, code, 13'b0}) - qhalf;
        den <= fac_gain * m_diff;
      end
      BK_DVD: begin
        dvd      <= DIFF_S * num;
        den_zero <= (den == '0);
      end
      BK_CAL:    cal <= quot_c + CAL_OFS_S + (cfg.pkg_comp ? PKG_COMP_ADD : '0);
      BK_SCALE:  tmp <= cal * TEMP_SCALE - TEMP_BIAS;
      BK_SAT: begin
        temp <= (cfg.emu_temp != '0) ? cfg.emu_temp : tmp_sat[EMU_BITS-1:0];
        if (cal < CAL_MIN)      cal_sat <= CAL_MIN[CAL_OUT_BITS-1:0];
        else if (cal > CAL_MAX) cal_sat <= CAL_MAX[CAL_OUT_BITS-1:0];
        else                    cal_sat <= cal[CAL_OUT_BITS-1:0];
      end
      default: ;
    endcase
  end

  // output register and hot flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      hot_flag     <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
      hot_flag     <= hot;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.code_used       <= code;
      result.calibrated_code <= cal_sat;
      result.temp_millideg   <= temp;
      result.hot_now         <= hot;
      result.hot_event       <= evt;
      result.critical        <= (temp > CRIT_LIMIT);
    end
  end

endmodule

FILE: tb/sv/thermal_code_calibrate_and_trip_tb.sv
`timescale 1ns / 100ps
// thermal_code_calibrate_and_trip_tb: self-checking bench for the calibrate-and-trip block,
// a directed table then random phases checked against a built-in calibration predictor
// depends on tcct_pkg, tcct_in_if, tcct_out_if and the rtl under rtl/core
module thermal_code_calibrate_and_trip_tb;
  import tcct_pkg::*;

  localparam longint STD_25C   = 2762;
  localparam longint STD_75C   = 2875;
  localparam longint STD_SPAN  = STD_75C - STD_25C;
  localparam longint STD_BASE  = (3 * STD_25C - STD_75C) / 2;
  localparam longint DEG_LO    = -2097152;
  localparam longint DEG_HI    = 2097151;
  localparam longint HOT_MDEG  = 90000;
  localparam longint CRIT_MDEG = 110000;
  localparam int     PHASES    = 8;
  localparam int     PER_PHASE = 128;
  localparam int     HOLD_OFF  = 600;

  typedef struct packed {
    code_t                          code_used;
    logic signed [CAL_OUT_BITS-1:0] cal_code;
    temp_t                          temp;
    logic                           hot_now;
    hot_evt_t                       hot_event;
    logic                           critical;
  } reading_t;

  typedef struct {
    bit       typed;
    reading_t want;
  } fixed_entry_t;

  typedef struct {
    bit          is_write;
    reg_idx_t    idx;
    logic [31:0] value;
    code_t       code;
    bit          typed;
    reading_t    want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tcct_in_if  sample_if ();
  tcct_out_if result_if ();

  // predictor state and register copy
  cfg_t     shadow;
  code_t    held_code;
  logic     hot_state;

  reading_t     pending_readings[$];
  fixed_entry_t fixed_readings[$];
  plan_row_t    plan[$];

  int unsigned mismatches;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;
  int unsigned hold_left;

  thermal_code_calibrate_and_trip DUT (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // calibration of one raw code, updating held code and hot flag
  function automatic reading_t calibrate_reading(input code_t raw);
    reading_t r;
    code_t    c;
    longint   gain, trim, m25, m75, offs, num, den, quot, cal, cal_clip, deg;
    bit       hot;
    if (raw == CODE_FAIL) begin
      c = held_code;
    end else begin
      held_code = raw;
      c = raw;
    end
    // segment trims, checked from the top down
    if (c > shadow.seg_upper) begin
      gain = 198;  trim = -16;
    end else if (c > shadow.m75) begin
      gain = 41;   trim = -3;
    end else if (c > shadow.seg_mid) begin
      gain = -111; trim = 7;
    end else if (c > shadow.m25) begin
      gain = 111;  trim = -2;
    end else if (c >= shadow.seg_low) begin
      gain = -233; trim = 5;
    end else if (c >= shadow.seg_bottom) begin
      gain = -250; trim = 5;
    end else begin
      gain = -267; trim = 5;
    end
    // two-point correction, truncating divisions
    m25  = longint'(shadow.m25);
    m75  = longint'(shadow.m75);
    offs = ((8192 + trim) * (3 * m25 - m75)) / 2;
    num  = longint'(c) * 8192 - offs;
    den  = (8192 + gain) * (m75 - m25);
    quot = (den != 0) ? (STD_SPAN * num) / den : 0;
    cal  = quot + STD_BASE;
    if (shadow.pkg_comp) cal += 18;
    // temperature from the unclipped code unless emulated
    if (shadow.emu_temp != 0) begin
      deg = shadow.emu_temp;
    end else begin
      deg = (cal * 10 - 27049) * 44;
      if (deg < DEG_LO) deg = DEG_LO;
      else if (deg > DEG_HI) deg = DEG_HI;
    end
    hot = deg > HOT_MDEG;
    r.hot_event = EVT_NONE;
    if (hot && !hot_state) r.hot_event = EVT_ENTER;
    else if (!hot && hot_state) r.hot_event = EVT_LEAVE;
    hot_state = hot;
    if (cal < -8192) cal_clip = -8192;
    else if (cal > 16383) cal_clip = 16383;
    else cal_clip = cal;
    r.code_used = c;
    r.cal_code  = cal_clip[CAL_OUT_BITS-1:0];
    r.temp      = deg[EMU_BITS-1:0];
    r.hot_now   = hot;
    r.critical  = deg > CRIT_MDEG;
    return r;
  endfunction

  // directed table rows
  function automatic void plan_reg(input reg_idx_t idx, input logic [31:0] value);
    plan_row_t row;
    row = '{is_write: 1'b0, idx: REG_SEG_UPPER, value: '0, code: '0, typed: 1'b0, want: '0};
    row.is_write = 1'b1;
    row.idx = idx;
    row.value = value;
    plan.push_back(row);
  endfunction

  function automatic void plan_code(input code_t code);
    plan_row_t row;
    row = '{is_write: 1'b0, idx: REG_SEG_UPPER, value: '0, code: '0, typed: 1'b0, want: '0};
    row.code = code;
    plan.push_back(row);
  endfunction

  function automatic void plan_fixed(input code_t code, input code_t used, input int cal,
                                     input int deg, input bit hot, input hot_evt_t ev,
                                     input bit crit);
    plan_row_t row;
    row = '{is_write: 1'b0, idx: REG_SEG_UPPER, value: '0, code: '0, typed: 1'b0, want: '0};
    row.code = code;
    row.typed = 1'b1;
    row.want.code_used = used;
    row.want.cal_code = cal[CAL_OUT_BITS-1:0];
    row.want.temp = deg[EMU_BITS-1:0];
    row.want.hot_now = hot;
    row.want.hot_event = ev;
    row.want.critical = crit;
    plan.push_back(row);
  endfunction

  // one apb write, shadow follows at the access edge
  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SEG_UPPER:  shadow.seg_upper = value[CODE_BITS-1:0];
      REG_SEG_MID:    shadow.seg_mid = value[CODE_BITS-1:0];
      REG_SEG_LOW:    shadow.seg_low = value[CODE_BITS-1:0];
      REG_SEG_BOTTOM: shadow.seg_bottom = value[CODE_BITS-1:0];
      REG_M25:        shadow.m25 = value[CODE_BITS-1:0];
      REG_M75:        shadow.m75 = value[CODE_BITS-1:0];
      REG_PKG_COMP:   shadow.pkg_comp = value[0];
      REG_EMU_TEMP:   shadow.emu_temp = value[EMU_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_readings();
    @(negedge clk);
    sample_if.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input int upper, input int mid, input int low, input int bottom,
                               input int m25, input int m75, input int comp, input int emu);
    drain_readings();
    write_register(REG_SEG_UPPER, upper);
    write_register(REG_SEG_MID, mid);
    write_register(REG_SEG_LOW, low);
    write_register(REG_SEG_BOTTOM, bottom);
    write_register(REG_M25, m25);
    write_register(REG_M75, m75);
    write_register(REG_PKG_COMP, comp);
    write_register(REG_EMU_TEMP, emu);
  endtask

  // offer one request, return at the accepting edge
  task automatic send_reading(input code_t code, input bit typed, input reading_t want);
    fixed_entry_t f;
    f.typed = typed;
    f.want = want;
    fixed_readings.push_back(f);
    @(negedge clk);
    while (src_gaps && $urandom_range(99) < 30) begin
      sample_if.valid = 1'b0;
      @(negedge clk);
    end
    sample_if.valid = 1'b1;
    sample_if.sensor_code = code;
    do @(posedge clk); while (!sample_if.ready);
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_if.ready = 1'b0;
    end else begin
      result_if.ready = !sink_gaps || ($urandom_range(99) >= 30);
    end
  end

  // accepted request: predict, or take the typed-in result
  always @(posedge clk) begin : accept_mon
    reading_t     r;
    fixed_entry_t f;
    if (!rst && sample_if.valid && sample_if.ready) begin
      r = calibrate_reading(sample_if.sensor_code);
      if (fixed_readings.size() != 0) begin
        f = fixed_readings.pop_front();
        if (f.typed) r = f.want;
      end
      pending_readings.push_back(r);
    end
  end

  // accepted result against the oldest expectation
  always @(posedge clk) begin : result_chk
    reading_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding, code_used %0d", result_if.code_used);
      end else begin
        want = pending_readings.pop_front();
        if (result_if.code_used !== want.code_used) begin
          mismatches++;
          $error("code_used: expected %0d, got %0d", want.code_used, result_if.code_used);
        end
        if (result_if.calibrated_code !== want.cal_code) begin
          mismatches++;
          $error("calibrated_code: expected %0d, got %0d", want.cal_code,
                 result_if.calibrated_code);
        end
        if (result_if.temp_millideg !== want.temp) begin
          mismatches++;
          $error("temp_millideg: expected %0d, got %0d", want.temp, result_if.temp_millideg);
        end
        if (result_if.hot_now !== want.hot_now) begin
          mismatches++;
          $error("hot_now: expected %0d, got %0d", want.hot_now, result_if.hot_now);
        end
        if (result_if.hot_event !== want.hot_event) begin
          mismatches++;
          $error("hot_event: expected %0d, got %0d", want.hot_event, result_if.hot_event);
        end
        if (result_if.critical !== want.critical) begin
          mismatches++;
          $error("critical: expected %0d, got %0d", want.critical, result_if.critical);
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    int       phase;
    int       n;
    int       anchor;
    int       sel;
    int       cuts[$];
    code_t    code;
    reading_t none;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.sensor_code = '0;
    result_if.ready = 1'b0;
    mismatches = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    none = '0;
    shadow.seg_upper = 3100;
    shadow.seg_mid = 2818;
    shadow.seg_low = 2600;
    shadow.seg_bottom = 2400;
    shadow.m25 = 2762;
    shadow.m75 = 2875;
    shadow.pkg_comp = 1'b0;
    shadow.emu_temp = '0;
    held_code = '0;
    hot_state = 1'b0;

    // directed table
    // failed read before any good read, then a zero code, both use code 0
    plan_fixed(CODE_FAIL, 0, -93, -1231076, 1'b0, EVT_NONE, 1'b0);
    plan_fixed(12'd0, 0, -93, -1231076, 1'b0, EVT_NONE, 1'b0);
    // emulated temperature around the hot and critical limits and at the extremes
    plan_reg(REG_EMU_TEMP, 90001);
    plan_fixed(CODE_FAIL, 0, -93, 90001, 1'b1, EVT_ENTER, 1'b0);
    plan_reg(REG_EMU_TEMP, 110001);
    plan_fixed(CODE_FAIL, 0, -93, 110001, 1'b1, EVT_NONE, 1'b1);
    plan_reg(REG_EMU_TEMP, 2097151);
    plan_fixed(CODE_FAIL, 0, -93, 2097151, 1'b1, EVT_NONE, 1'b1);
    plan_reg(REG_EMU_TEMP, 90000);
    plan_fixed(CODE_FAIL, 0, -93, 90000, 1'b0, EVT_LEAVE, 1'b0);
    plan_reg(REG_EMU_TEMP, -2097152);
    plan_fixed(CODE_FAIL, 0, -93, -2097152, 1'b0, EVT_NONE, 1'b0);
    plan_reg(REG_EMU_TEMP, 0);
    // every segment and both sides of each boundary
    plan_code(12'd4094);
    plan_code(12'd3101);
    plan_code(12'd3100);
    plan_code(12'd3000);
    plan_code(12'd2876);
    plan_code(12'd2875);
    plan_code(12'd2819);
    plan_code(12'd2818);
    plan_code(12'd2763);
    plan_code(12'd2762);
    plan_code(12'd2600);
    plan_code(12'd2599);
    plan_code(12'd2400);
    plan_code(12'd2399);
    plan_code(CODE_FAIL);
    // package compensation
    plan_reg(REG_PKG_COMP, 1);
    plan_code(12'd2875);
    plan_reg(REG_PKG_COMP, 0);
    // equal measured codes give a zero divisor
    plan_reg(REG_M75, 2762);
    plan_fixed(12'd2000, 2000, 2705, 44, 1'b0, EVT_NONE, 1'b0);
    // calibrated code and temperature saturating high, then low
    plan_reg(REG_M25, 0);
    plan_reg(REG_M75, 1);
    plan_code(12'd4094);
    plan_reg(REG_M25, 1);
    plan_reg(REG_M75, 0);
    plan_code(12'd4094);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_readings();
        write_register(plan[i].idx, plan[i].value);
      end else begin
        send_reading(plan[i].code, plan[i].typed, plan[i].want);
      end
    end

    // random phases, one register setting each
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_setting(3100, 2818, 2600, 2400, 2762, 2875, 0, 0);
        2: write_setting(0, 0, 0, 0, 0, 0, 1, 0);
        3: write_setting(4095, 4095, 4095, 4095, 0, 4095, 0, 0);
        4: write_setting($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(1), 0);
        5: write_setting(3100, 2818, 2600, 2400, 2762, 2875, 0, $urandom_range(32'h3fffff));
        6: write_setting(3100, 2818, 2600, 2400, 2762, 2875, 1, 0);
        default: begin
          // ordered thresholds around the usual operating range
          cuts.delete();
          repeat (6) cuts.push_back($urandom_range(1500, 3500));
          cuts.sort();
          write_setting(cuts[5], cuts[3], cuts[1], cuts[0], cuts[2], cuts[4],
                        $urandom_range(1), 0);
        end
      endcase
      // one stretch with no idling on either side
      src_gaps = (phase != 6);
      sink_gaps = (phase != 6);
      for (n = 0; n < PER_PHASE; n++) begin
        if (phase == 1 && n == 30) hold_req = 1'b1;
        if (phase == 2 && n == 60) drain_readings();
        sel = $urandom_range(99);
        if (sel < 8) begin
          code = CODE_FAIL;
        end else if (sel < 30) begin
          // near a segment boundary
          case ($urandom_range(5))
            0: anchor = shadow.seg_upper;
            1: anchor = shadow.seg_mid;
            2: anchor = shadow.seg_low;
            3: anchor = shadow.seg_bottom;
            4: anchor = shadow.m25;
            default: anchor = shadow.m75;
          endcase
          anchor = anchor + $urandom_range(2) - 1;
          if (anchor < 0) anchor = 0;
          if (anchor > 4094) anchor = 4094;
          code = anchor[CODE_BITS-1:0];
        end else begin
          code = $urandom_range(4094);
        end
        send_reading(code, 1'b0, none);
      end
    end

    drain_readings();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
